// File: rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, types and helpers for the palette RAM port.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // Colors per palette unit (2 to 32)
  localparam int COLOR_ENTRIES = 32;
  localparam int ENTRY_W       = $clog2(COLOR_ENTRIES);
  localparam int ADDR_W        = ENTRY_W + 1;
  localparam int MEM_DEPTH     = 2 ** ADDR_W;

  localparam int COLOR_W = 15;
  localparam int POS_W   = 6;

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Register selects
  localparam logic [1:0] REG_BG_INDEX  = 2'd0;
  localparam logic [1:0] REG_BG_DATA   = 2'd1;
  localparam logic [1:0] REG_OBJ_INDEX = 2'd2;
  localparam logic [1:0] REG_OBJ_DATA  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_LOAD
  } cpr_state_t;

  typedef logic [COLOR_W-1:0] color_t;

  // True when the entry named by a byte position exists
  function automatic logic entry_in_range(input logic [POS_W-1:0] pos);
    return {1'b0, pos[POS_W-1:1]} < 6'(COLOR_ENTRIES);
  endfunction

  // Memory address of a byte position within a unit
  function automatic logic [ADDR_W-1:0] mem_addr(input logic unit,
                                                 input logic [POS_W-1:0] pos);
    return {unit, pos[ENTRY_W:1]};
  endfunction

  // High byte has bit7 always zero
  function automatic logic [7:0] color_byte(input color_t c, input logic hi);
    return hi ? {1'b0, c[14:8]} : c[7:0];
  endfunction

  function automatic color_t color_merge(input color_t c, input logic hi,
                                         input logic [7:0] data);
    return hi ? {data[6:0], c[7:0]} : {c[14:8], data};
  endfunction

endpackage

// File: rtl/color_palette_ram_port.sv
// ----------------------------------------------------------------------------
// color_palette_ram_port
// Background and object palette units with index, data latch and
// auto-increment, colors held in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req      | in        | req_valid/req_stall  | func, reg_select, write_data
//  rsp      | out       | rsp_valid/rsp_stall  | read_data
//
//  A read stays in ST_IDLE; an index write passes through ST_LOAD and a data
//  write through ST_MERGE, then ST_LOAD with auto-increment, waiting on the
//  RAM read for the merge and the latch reload; one item in flight at a time.
//  Reset clears both palettes at once through per-entry valid bits (an
//  entry not yet written reads as zero), plus indexes and latches.
//  The response is registered at accept; a stalled response blocks new items.
// ----------------------------------------------------------------------------
module color_palette_ram_port (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       func,
  input  logic [1:0] reg_select,
  input  logic [7:0] write_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data
);
  import cpr_pkg::*;

  cpr_state_t state, state_next;

  logic [7:0] bg_index, obj_index, bg_latch, obj_latch;

  // Context of the item in progress
  logic             op_unit;
  logic [POS_W-1:0] op_pos;
  logic [7:0]       op_data;
  logic             op_inc;

  // Color RAM
  color_t              mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] entry_valid;
  color_t              rdata;
  logic                rd_ok;
  logic                rd_en, rd_range;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  color_t              wr_data;

  // Forward a color written in the same cycle as its reload
  logic   fwd_hit;
  color_t fwd_color;

  logic             take;
  logic             sel_unit, sel_data;
  logic [7:0]       cur_index, op_index;
  logic [POS_W-1:0] next_pos;
  color_t           cur_color;

  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign take      = req_valid && !req_stall;
  assign sel_unit  = reg_select[1];
  assign sel_data  = reg_select[0];
  assign cur_index = sel_unit ? obj_index : bg_index;
  assign op_index  = op_unit ? obj_index : bg_index;
  assign next_pos  = op_pos + POS_W'(1);
  assign cur_color = fwd_hit ? fwd_color : (rd_ok ? rdata : '0);

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = mem_addr(sel_unit, write_data[POS_W-1:0]);
    rd_range   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = mem_addr(op_unit, op_pos);
    wr_data    = color_merge(cur_color, op_pos[0], op_data);
    case (state)
      ST_IDLE: begin
        if (take && func == FUNC_WRITE) begin
          rd_en = 1'b1;
          if (sel_data) begin
            rd_addr    = mem_addr(sel_unit, cur_index[POS_W-1:0]);
            rd_range   = entry_in_range(cur_index[POS_W-1:0]);
            state_next = ST_MERGE;
          end else begin
            rd_range   = entry_in_range(write_data[POS_W-1:0]);
            state_next = ST_LOAD;
          end
        end
      end
      ST_MERGE: begin
        wr_en = entry_in_range(op_pos);
        if (op_inc) begin
          rd_en      = 1'b1;
          rd_addr    = mem_addr(op_unit, next_pos);
          rd_range   = entry_in_range(next_pos);
          state_next = ST_LOAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LOAD: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // RAM array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_ok       <= 1'b0;
      fwd_hit     <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= rd_range && entry_valid[rd_addr];
      end
      fwd_hit <= wr_en && rd_en && (next_pos[POS_W-1:1] == op_pos[POS_W-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    fwd_color <= wr_data;
    if (take) begin
      op_unit <= sel_unit;
      op_data <= write_data;
      op_pos  <= sel_data ? cur_index[POS_W-1:0] : write_data[POS_W-1:0];
      op_inc  <= cur_index[7];
    end else if (state == ST_MERGE) begin
      op_pos <= next_pos;
    end
  end

  // Index and latch registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_index  <= '0;
      obj_index <= '0;
      bg_latch  <= '0;
      obj_latch <= '0;
    end else begin
      if (take && func == FUNC_WRITE) begin
        case (reg_select)
          REG_BG_INDEX:  bg_index  <= write_data;
          REG_BG_DATA:   bg_latch  <= write_data;
          REG_OBJ_INDEX: obj_index <= write_data;
          REG_OBJ_DATA:  obj_latch <= write_data;
          default: ;
        endcase
      end
      // Advance the position, keep bit7, clear bit6
      if (state == ST_MERGE && op_inc) begin
        if (op_unit) begin
          obj_index <= {op_index[7], 1'b0, next_pos};
        end else begin
          bg_index <= {op_index[7], 1'b0, next_pos};
        end
      end
      if (state == ST_LOAD) begin
        if (op_unit) begin
          obj_latch <= color_byte(cur_color, op_pos[0]);
        end else begin
          bg_latch <= color_byte(cur_color, op_pos[0]);
        end
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (func == FUNC_READ) begin
        case (reg_select)
          REG_BG_INDEX:  read_data <= bg_index;
          REG_BG_DATA:   read_data <= bg_latch;
          REG_OBJ_INDEX: read_data <= obj_index;
          REG_OBJ_DATA:  read_data <= obj_latch;
          default:       read_data <= '0;
        endcase
      end else begin
        read_data <= '0;
      end
    end
  end

  // Checks
  a_write_in_merge: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_MERGE)
    else $error("color RAM written outside merge");

  a_fwd_to_load: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> state == ST_LOAD)
    else $error("forwarded color not consumed by reload");

  a_item_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp_valid)
    else $error("accepted item produced no response");

  a_latch_keeps_data: assert property (@(posedge clk) disable iff (rst)
    (take && func == FUNC_WRITE && reg_select == REG_BG_DATA && !bg_index[7])
      |=> bg_latch == $past(write_data))
    else $error("latch lost written byte");

  a_inc_clears_bit6: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE && op_inc && !op_unit) |=> !bg_index[6] && bg_index[7])
    else $error("auto-increment left index bit6 set");

endmodule
